### rtl/orc_pkg.sv
`default_nettype none

package orc_pkg;

  localparam int unsigned CoordW  = 8;
  localparam int unsigned LevelW  = 16;
  localparam int unsigned CostW   = 16;
  localparam int unsigned RewardW = 24;
  localparam int unsigned DimW    = 9;
  localparam int unsigned MarginW = 8;
  localparam int unsigned ErrW    = 10;
  localparam int unsigned RegIdxW = 3;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_REPORT
  } orc_state_e;

  typedef enum logic [RegIdxW-1:0] {
    REG_MAP_COLUMNS    = 3'd0,
    REG_MAP_ROWS       = 3'd1,
    REG_OCCUPIED_LEVEL = 3'd2,
    REG_CROSSING_COST  = 3'd3,
    REG_COST_CAP       = 3'd4,
    REG_HIT_MARGIN     = 3'd5,
    REG_FREE_GAIN      = 3'd6
  } orc_reg_e;

  // One stepped cell as it leaves the line walker.
  typedef struct packed {
    logic vld;
    logic last;
    logic pen;
  } orc_walk_t;

  // One cell as it reaches the scoring unit, aligned with the map read word.
  typedef struct packed {
    logic vld;
    logic ok;
    logic pen;
    logic last;
  } orc_step_t;

endpackage

`default_nettype wire

### rtl/orc_map_ram.sv
`default_nettype none

module orc_map_ram #(
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [15:0]   wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [15:0]   rdata_o
);

  logic [15:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

### rtl/orc_walker.sv
`default_nettype none

module orc_walker (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          load_i,
  input  wire logic [orc_pkg::CoordW-1:0]    start_col_i,
  input  wire logic [orc_pkg::CoordW-1:0]    start_row_i,
  input  wire logic [orc_pkg::CoordW-1:0]    stop_col_i,
  input  wire logic [orc_pkg::CoordW-1:0]    stop_row_i,
  input  wire logic                          hit_excl_i,
  input  wire logic [orc_pkg::MarginW-1:0]   margin_i,
  output orc_pkg::orc_walk_t                 walk_o,
  output logic      [orc_pkg::CoordW-1:0]    col_o,
  output logic      [orc_pkg::CoordW-1:0]    row_o
);
  import orc_pkg::*;

  logic                    active_q, active_d;
  logic [CoordW-1:0]       col_q, col_d, row_q, row_d;
  logic [ErrW-1:0]         err_q, err_d;
  logic [CoordW-1:0]       adx_q, adx_d, ady_q, ady_d, m_q, m_d, idx_q, idx_d;
  logic                    sxn_q, sxn_d, syn_q, syn_d;
  logic [CoordW:0]         lim_q, lim_d;
  orc_walk_t               out_q, out_d;

  logic signed [CoordW:0]  dx_s, dy_s;
  logic [CoordW-1:0]       adx_in, ady_in, m_in;
  logic [CoordW:0]         n_in, margin_ext;
  logic signed [ErrW:0]    e2, neg_dy, err_wide;
  logic                    step_col, step_row;

  always_comb begin
    dx_s       = $signed({1'b0, stop_col_i}) - $signed({1'b0, start_col_i});
    dy_s       = $signed({1'b0, stop_row_i}) - $signed({1'b0, start_row_i});
    adx_in     = dx_s[CoordW] ? CoordW'(-dx_s) : dx_s[CoordW-1:0];
    ady_in     = dy_s[CoordW] ? CoordW'(-dy_s) : dy_s[CoordW-1:0];
    m_in       = (adx_in > ady_in) ? adx_in : ady_in;
    n_in       = {1'b0, m_in} + (CoordW+1)'(1);
    margin_ext = (CoordW+1)'(margin_i);

    // Error term update of one Bresenham step, both moves tested on the old error.
    e2       = $signed({err_q, 1'b0});
    neg_dy   = -$signed({3'b000, ady_q});
    step_col = e2 > neg_dy;
    step_row = e2 < $signed({3'b000, adx_q});
    err_wide = $signed({err_q[ErrW-1], err_q})
             - (step_col ? $signed({3'b000, ady_q}) : '0)
             + (step_row ? $signed({3'b000, adx_q}) : '0);
  end

  always_comb begin
    active_d = active_q;
    col_d    = col_q;
    row_d    = row_q;
    err_d    = err_q;
    adx_d    = adx_q;
    ady_d    = ady_q;
    m_d      = m_q;
    idx_d    = idx_q;
    sxn_d    = sxn_q;
    syn_d    = syn_q;
    lim_d    = lim_q;
    out_d    = '0;
    if (load_i) begin
      active_d = 1'b1;
      col_d    = start_col_i;
      row_d    = start_row_i;
      err_d    = {2'b00, adx_in} - {2'b00, ady_in};
      adx_d    = adx_in;
      ady_d    = ady_in;
      m_d      = m_in;
      idx_d    = CoordW'(1);
      sxn_d    = !(dx_s > 0);
      syn_d    = !(dy_s > 0);
      if (hit_excl_i) begin
        lim_d = (margin_ext >= n_in) ? (CoordW+1)'(1) : n_in - margin_ext;
      end else begin
        lim_d = n_in;
      end
    end else if (active_q) begin
      if (step_col) begin
        col_d = col_q + (sxn_q ? {CoordW{1'b1}} : CoordW'(1));
      end
      if (step_row) begin
        row_d = row_q + (syn_q ? {CoordW{1'b1}} : CoordW'(1));
      end
      err_d     = err_wide[ErrW-1:0];
      idx_d     = idx_q + CoordW'(1);
      out_d.vld  = 1'b1;
      out_d.last = (idx_q == m_q);
      out_d.pen  = {1'b0, idx_q} < lim_q;
      if (idx_q == m_q) begin
        active_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      out_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      err_q    <= '0;
    end else begin
      active_q <= active_d;
      out_q    <= out_d;
      col_q    <= col_d;
      row_q    <= row_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    adx_q <= adx_d;
    ady_q <= ady_d;
    m_q   <= m_d;
    idx_q <= idx_d;
    sxn_q <= sxn_d;
    syn_q <= syn_d;
    lim_q <= lim_d;
  end

  assign walk_o = out_q;
  assign col_o  = col_q;
  assign row_o  = row_q;

endmodule

`default_nettype wire

### rtl/orc_scorer.sv
`default_nettype none

module orc_scorer (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               init_i,
  input  wire orc_pkg::orc_step_t                 step_i,
  input  wire logic signed [orc_pkg::LevelW-1:0]  level_i,
  input  wire logic signed [orc_pkg::LevelW-1:0]  thr_i,
  input  wire logic        [orc_pkg::CostW-1:0]   cost_i,
  input  wire logic        [orc_pkg::CostW-1:0]   cap_i,
  input  wire logic        [orc_pkg::CostW-1:0]   gain_i,
  output logic             [orc_pkg::CostW-1:0]   penalty_o,
  output logic             [orc_pkg::RewardW-1:0] reward_o
);
  import orc_pkg::*;

  logic [CostW-1:0]   pen_q, pen_d;
  logic [RewardW-1:0] rew_q, rew_d;
  logic               in_run_q, in_run_d;
  logic               stopped_q, stopped_d;
  logic [CostW:0]     pen_sum;

  always_comb begin
    pen_sum   = {1'b0, pen_q} + {1'b0, cost_i};
    pen_d     = pen_q;
    rew_d     = rew_q;
    in_run_d  = in_run_q;
    stopped_d = stopped_q;
    if (init_i) begin
      pen_d     = '0;
      rew_d     = '0;
      in_run_d  = 1'b0;
      stopped_d = (gain_i == '0);
    end else if (step_i.vld) begin
      // Only the first cell of an occupied run is charged.
      if (step_i.pen) begin
        if (level_i >= thr_i) begin
          if (!in_run_q) begin
            pen_d    = (pen_sum > {1'b0, cap_i}) ? cap_i : pen_sum[CostW-1:0];
            in_run_d = 1'b1;
          end
        end else begin
          in_run_d = 1'b0;
        end
      end
      if (!stopped_q) begin
        if (step_i.ok && level_i[LevelW-1]) begin
          rew_d = rew_q + RewardW'(gain_i);
        end else begin
          stopped_d = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pen_q     <= '0;
      rew_q     <= '0;
      in_run_q  <= 1'b0;
      stopped_q <= 1'b0;
    end else begin
      pen_q     <= pen_d;
      rew_q     <= rew_d;
      in_run_q  <= in_run_d;
      stopped_q <= stopped_d;
    end
  end

  assign penalty_o = pen_q;
  assign reward_o  = rew_q;

endmodule

`default_nettype wire

### rtl/occupancy_ray_crossing_scorer.sv
// Cell write: no result word; busy stays low.
// Ray: the line walker steps one cell per cycle through the single map read port, the scorer
// sums each cell read, and the report state then registers the result word and strobe.
// A ray with an invalid start or no step goes to the report state without walking. One item at a time.
// Reset clears the map by writing zero to all MAP_DIM*MAP_DIM cells; busy is high meanwhile.
// The result word is shown for one cycle on result_valid_o; the receiver cannot stall.
`default_nettype none

module occupancy_ray_crossing_scorer #(
  parameter int MAP_DIM = 256
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               cfg_we_i,
  input  wire logic [orc_pkg::RegIdxW-1:0]        cfg_idx_i,
  input  wire logic [orc_pkg::LevelW-1:0]         cfg_wdata_i,
  input  wire logic                               start_i,
  output logic                                    busy,
  input  wire logic                               kind_i,
  input  wire logic [orc_pkg::CoordW-1:0]         start_col_i,
  input  wire logic [orc_pkg::CoordW-1:0]         start_row_i,
  input  wire logic [orc_pkg::CoordW-1:0]         stop_col_i,
  input  wire logic [orc_pkg::CoordW-1:0]         stop_row_i,
  input  wire logic signed [orc_pkg::LevelW-1:0]  cell_level_i,
  input  wire logic                               beam_hit_i,
  input  wire logic                               end_clipped_i,
  output logic                                    result_valid_o,
  output logic [orc_pkg::CostW-1:0]               ray_penalty_o,
  output logic [orc_pkg::RewardW-1:0]             free_reward_o
);
  import orc_pkg::*;

  localparam int DEPTH = MAP_DIM * MAP_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = ($clog2(MAP_DIM + 1) > DimW) ? $clog2(MAP_DIM + 1) : DimW;
  localparam int SW    = (AW > CoordW + DW + 1) ? AW : CoordW + DW + 1;
  localparam logic [DW-1:0] DimLimit = DW'(MAP_DIM);

  orc_state_e state_q, state_d;

  logic [DimW-1:0]    map_columns_q, map_rows_q;
  logic [LevelW-1:0]  occupied_level_q;
  logic [CostW-1:0]   crossing_cost_q, cost_cap_q, free_gain_q;
  logic [MarginW-1:0] hit_margin_q;

  logic [AW-1:0]      clr_q, clr_d;
  logic               clr_last;
  logic               hit_q;

  logic [DW-1:0]      cols_ext, rows_ext, eff_cols, eff_rows;
  logic [CoordW-1:0]  sel_col, sel_row, walk_col, walk_row;
  logic               cell_ok;
  logic [SW-1:0]      cell_sum;
  logic [AW-1:0]      cell_addr;

  logic               accept, ray_acc, ray_steps, walk_load, score_init;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [LevelW-1:0]  ram_wdata, ram_rdata;

  orc_walk_t          walk;
  orc_step_t          ev_q, ev_d;

  logic [CostW-1:0]   penalty;
  logic [RewardW-1:0] reward;
  logic               res_vld_q, res_vld_d;
  logic [CostW-1:0]   res_pen_q;
  logic [RewardW-1:0] res_rew_q;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_columns_q    <= DimW'(256);
      map_rows_q       <= DimW'(256);
      occupied_level_q <= '0;
      crossing_cost_q  <= CostW'(256);
      cost_cap_q       <= CostW'(1024);
      hit_margin_q     <= MarginW'(2);
      free_gain_q      <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MAP_COLUMNS:    map_columns_q    <= cfg_wdata_i[DimW-1:0];
        REG_MAP_ROWS:       map_rows_q       <= cfg_wdata_i[DimW-1:0];
        REG_OCCUPIED_LEVEL: occupied_level_q <= cfg_wdata_i;
        REG_CROSSING_COST:  crossing_cost_q  <= cfg_wdata_i;
        REG_COST_CAP:       cost_cap_q       <= cfg_wdata_i;
        REG_HIT_MARGIN:     hit_margin_q     <= cfg_wdata_i[MarginW-1:0];
        REG_FREE_GAIN:      free_gain_q      <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Shared cell check and address unit: the walker cell in the walk state, the input cell otherwise.
  always_comb begin
    cols_ext  = DW'(map_columns_q);
    rows_ext  = DW'(map_rows_q);
    eff_cols  = (cols_ext > DimLimit) ? DimLimit : cols_ext;
    eff_rows  = (rows_ext > DimLimit) ? DimLimit : rows_ext;
    sel_col   = (state_q == ST_WALK) ? walk_col : start_col_i;
    sel_row   = (state_q == ST_WALK) ? walk_row : start_row_i;
    cell_ok   = (DW'(sel_col) < eff_cols) && (DW'(sel_row) < eff_rows);
    cell_sum  = SW'(sel_row) * SW'(eff_cols) + SW'(sel_col);
    cell_addr = cell_sum[AW-1:0];
  end

  assign accept    = start_i && (state_q == ST_IDLE);
  assign ray_acc   = accept && kind_i;
  assign ray_steps = (start_col_i != stop_col_i) || (start_row_i != stop_row_i);
  assign clr_last  = (clr_q == AW'(DEPTH - 1));

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (ray_acc) begin
          state_d = (cell_ok && ray_steps) ? ST_WALK : ST_REPORT;
        end
      end
      ST_WALK: begin
        if (ev_q.vld && ev_q.last) begin
          state_d = ST_REPORT;
        end
      end
      ST_REPORT: state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // State outputs.
  always_comb begin
    busy       = (state_q != ST_IDLE);
    walk_load  = ray_acc && cell_ok && ray_steps;
    score_init = ray_acc;
    clr_d      = clr_q;
    res_vld_d  = (state_q == ST_REPORT);
    ram_we     = 1'b0;
    ram_waddr  = cell_addr;
    ram_wdata  = cell_level_i;
    if (state_q == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_q;
      ram_wdata = '0;
      clr_d     = clr_q + AW'(1);
    end else if (accept && !kind_i && cell_ok) begin
      ram_we = 1'b1;
    end
  end

  always_comb begin
    ev_d.vld  = walk.vld;
    ev_d.ok   = cell_ok;
    ev_d.pen  = walk.pen && cell_ok;
    ev_d.last = walk.last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_q     <= '0;
      ev_q      <= '0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      ev_q      <= ev_d;
      res_vld_q <= res_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ray_acc) begin
      hit_q <= beam_hit_i;
    end
    if (state_q == ST_REPORT) begin
      res_pen_q <= penalty;
      res_rew_q <= hit_q ? '0 : reward;
    end
  end

  orc_map_ram #(
    .DEPTH(DEPTH)
  ) u_map_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .re_i   (walk.vld),
    .raddr_i(cell_addr),
    .rdata_o(ram_rdata)
  );

  orc_walker u_walker (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (walk_load),
    .start_col_i(start_col_i),
    .start_row_i(start_row_i),
    .stop_col_i (stop_col_i),
    .stop_row_i (stop_row_i),
    .hit_excl_i (beam_hit_i && !end_clipped_i),
    .margin_i   (hit_margin_q),
    .walk_o     (walk),
    .col_o      (walk_col),
    .row_o      (walk_row)
  );

  orc_scorer u_scorer (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .init_i   (score_init),
    .step_i   (ev_q),
    .level_i  ($signed(ram_rdata)),
    .thr_i    ($signed(occupied_level_q)),
    .cost_i   (crossing_cost_q),
    .cap_i    (cost_cap_q),
    .gain_i   (free_gain_q),
    .penalty_o(penalty),
    .reward_o (reward)
  );

  assign result_valid_o = res_vld_q;
  assign ray_penalty_o  = res_pen_q;
  assign free_reward_o  = res_rew_q;

endmodule

`default_nettype wire
